### rtl/arow_pkg.sv
// ----------------------------------------------------------------------------
// arow_pkg
// Shared types and constants of the diagonal AROW active learner.
// ----------------------------------------------------------------------------
`default_nettype none

package arow_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MODE = 2'd0;
  localparam logic [1:0] CFG_REG_R = 2'd1;
  localparam logic [1:0] CFG_STEP_ETA = 2'd2;
  localparam logic [1:0] CFG_SAMPLE_B = 2'd3;

  // Query rules.
  localparam logic [1:0] MODE_ALWAYS = 2'd0;
  localparam logic [1:0] MODE_MARGIN = 2'd1;
  localparam logic [1:0] MODE_RHO = 2'd2;
  localparam logic [1:0] MODE_FIXED = 2'd3;

  // Fixed-point constants.
  localparam logic [31:0] ONE_Q31 = 32'h8000_0000;
  localparam logic signed [63:0] ONE_Q28 = 64'sh0000_0000_1000_0000;
  localparam logic [51:0] MAG_CAP = 52'h0_4000_0000_0000;
  localparam logic [31:0] REG_RESET = 32'h0001_0000;

  // Width of the confidence-weighted norm (enough for the largest feature count).
  localparam int VW = 48;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ACC,
    ST_END,
    ST_NRD,
    ST_NSQ,
    ST_NACC,
    ST_DEC,
    ST_HDIV,
    ST_HMUL,
    ST_TERM,
    ST_RHO,
    ST_DRWA,
    ST_DRWB,
    ST_QRY,
    ST_URD,
    ST_USQ,
    ST_UT,
    ST_UPRD,
    ST_UDIV,
    ST_USUB,
    ST_UM,
    ST_UST,
    ST_UWR,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

### rtl/arow_if.sv
// ----------------------------------------------------------------------------
// arow_in_if / arow_out_if
// Valid/ready channels for feature beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface arow_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] feature;
  logic               label;
  logic        [15:0] random_draw;
  logic               last;

  modport source (output valid, feature, label, random_draw, last, input ready);
  modport sink (input valid, feature, label, random_draw, last, output ready);
endinterface

interface arow_out_if;
  logic        valid;
  logic        ready;
  logic        predicted_label;
  logic        queried;
  logic        updated;
  logic        skipped;
  logic [31:0] true_pos_count;
  logic [31:0] true_neg_count;
  logic [31:0] false_pos_count;
  logic [31:0] false_neg_count;
  logic [31:0] query_count;

  modport source (output valid, predicted_label, queried, updated, skipped,
                  true_pos_count, true_neg_count, false_pos_count,
                  false_neg_count, query_count, input ready);
  modport sink (input valid, predicted_label, queried, updated, skipped,
                true_pos_count, true_neg_count, false_pos_count,
                false_neg_count, query_count, output ready);
endinterface

`default_nettype wire

### rtl/arow_ram.sv
// ----------------------------------------------------------------------------
// arow_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module arow_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/arow_div.sv
// ----------------------------------------------------------------------------
// arow_div
// Iterative restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module arow_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [63:0] divisor,
  output logic             done,
  output logic      [63:0] quotient
);

  logic [64:0] rem;
  logic [63:0] dvs;
  logic [6:0]  cnt;
  logic        busy;
  logic [64:0] shifted;

  assign shifted = {rem[63:0], quotient[63]};

  // Control: count the 64 steps and flag the last one.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: the quotient register also shifts out the dividend bits.
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (shifted >= {1'b0, dvs}) begin
        rem      <= shifted - {1'b0, dvs};
        quotient <= {quotient[62:0], 1'b1};
      end else begin
        rem      <= shifted;
        quotient <= {quotient[62:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

### rtl/arow_diagonal_active_learner_top.sv
// ----------------------------------------------------------------------------
// arow_diagonal_active_learner_top
// Online linear classifier with diagonal AROW and label-query control.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one feature per beat; the beat with last set also carries
//   the label and the random draw. out_ch carries one result beat per sample.
//   The user must write the configuration port only while no sample is in
//   flight; the block itself does not enforce it.
// Flow:
//   Each feature is taken with a weight memory read, then a multiply and add.
//   After the last feature, an all-zero sample goes straight to the finish.
//   Otherwise a norm pass reads each stored feature, the decision follows (with
//   a division in the adjusted-margin rule), and an update runs over each
//   feature, with the bit-serial divider producing its confidence decrement.
// Reset:
//   Weights read as zero and confidences as one until first written, tracked
//   by a fill mark, so there is no clearing pass. Counts and registers return
//   to their defaults.
// Stall:
//   The result sits in an output register; the next sample's features are
//   taken meanwhile, and only its result waits until the beat is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module arow_diagonal_active_learner_top #(
  parameter int FEATURES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  arow_in_if.sink          in_ch,
  arow_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  import arow_pkg::*;

  localparam int AW = (FEATURES > 1) ? $clog2(FEATURES) : 1;
  localparam int PW = $clog2(FEATURES + 1);

  state_t state, state_next;

  logic [1:0]  mode;
  logic [31:0] reg_r, step_eta, sample_b;

  logic [PW-1:0]      pos, idx, nfeat;
  logic signed [63:0] score;
  logic               nonzero;
  logic signed [15:0] x_reg;
  logic               last_reg, label_reg;
  logic [15:0]        draw_reg;

  logic [VW-1:0]      v;
  logic [31:0]        x2, s_reg, t_reg, snew;
  logic signed [31:0] w_reg;
  logic signed [15:0] xs;
  logic [48:0]        den_reg;
  logic               pred, q_r, u_r, skip_r;
  logic [63:0]        mag_sel, ds;
  logic [47:0]        s_draw;
  logic [16:0]        hq;
  logic [39:0]        h;
  logic [58:0]        term;
  logic [20:0]        m;
  logic [36:0]        step;
  logic [PW-1:0]      fill;
  logic [31:0]        tp, tn, fp, fn, qc;

  // Memory ports.
  logic [15:0] smp_rd;
  logic [31:0] w_rd, c_rd;
  logic        smp_we, upd_we;
  logic [AW-1:0] smp_waddr, rd_addr, w_raddr;
  logic signed [31:0] w_wdata;

  // Divider.
  logic        div_start, div_done;
  logic [63:0] div_dvd, div_dvs, div_q;

  // ---------------------------------------------------------------------------
  // Combinational helpers.
  // ---------------------------------------------------------------------------
  logic               accept;
  logic               has_room;
  logic               rd_written;
  logic signed [31:0] w_eff;
  logic [31:0]        c_eff;
  logic signed [47:0] acc_prod;
  logic signed [31:0] smp_sq;
  logic [63:0]        ap_c;
  logic               hinge_c;
  logic [39:0]        rr;
  logic [48:0]        rrv;
  logic [51:0]        p_sh;
  logic [46:0]        p_cap;
  logic [63:0]        draw_prod;
  logic               draw_ok;
  logic [63:0]        sq_prod;
  logic [15:0]        ax;
  logic signed [38:0] nw;
  logic               neg;
  logic               out_free;

  assign accept     = in_ch.valid && in_ch.ready;
  assign has_room   = pos < PW'(FEATURES);
  assign rd_written = PW'(rd_addr) < fill;
  assign w_eff      = rd_written ? $signed(w_rd) : 32'sd0;
  assign c_eff      = rd_written ? c_rd : ONE_Q31;
  assign acc_prod   = x_reg * w_eff;
  assign smp_sq     = $signed(smp_rd) * $signed(smp_rd);
  assign ap_c       = score[63] ? (64'd0 - 64'(score)) : 64'(score);
  assign hinge_c    = label_reg ? (score < ONE_Q28) : (score > -ONE_Q28);
  assign rr         = {reg_r, 8'd0};
  assign rrv        = 49'(rr) + 49'(v);
  assign p_sh       = mag_sel[63:12];
  assign p_cap      = (p_sh > MAG_CAP) ? MAG_CAP[46:0] : p_sh[46:0];
  assign draw_prod  = 64'(draw_reg) * 64'(s_draw);
  assign draw_ok    = (s_draw != 48'd0) && (draw_prod <= {16'd0, sample_b, 16'd0});
  assign sq_prod    = 64'(x2) * 64'(s_reg);
  assign ax         = xs[15] ? (~xs + 16'd1) : xs;
  assign neg        = xs[15] != !label_reg;
  assign nw         = neg ? (39'(w_reg) - $signed({2'b00, step}))
                          : (39'(w_reg) + $signed({2'b00, step}));
  assign out_free   = !out_ch.valid || out_ch.ready;

  // ---------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_ALWAYS;
      reg_r    <= REG_RESET;
      step_eta <= REG_RESET;
      sample_b <= REG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:     mode <= cfg_data[1:0];
        CFG_REG_R:    reg_r <= cfg_data;
        CFG_STEP_ETA: step_eta <= cfg_data;
        CFG_SAMPLE_B: sample_b <= cfg_data;
        default:      mode <= mode;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // State register and next state.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (has_room) begin
            state_next = ST_ACC;
          end else if (in_ch.last) begin
            state_next = ST_END;
          end
        end
      end
      ST_ACC:  state_next = last_reg ? ST_END : ST_IDLE;
      ST_END:  state_next = nonzero ? ST_NRD : ST_FIN;
      ST_NRD:  state_next = ST_NSQ;
      ST_NSQ:  state_next = ST_NACC;
      ST_NACC: state_next = (idx + PW'(1) == nfeat) ? ST_DEC : ST_NRD;
      ST_DEC: begin
        case (mode)
          MODE_MARGIN: state_next = ST_DRWA;
          MODE_RHO:    state_next = (rrv != 49'd0) ? ST_HDIV : ST_HMUL;
          default:     state_next = ST_QRY;
        endcase
      end
      ST_HDIV: state_next = div_done ? ST_HMUL : ST_HDIV;
      ST_HMUL: state_next = ST_TERM;
      ST_TERM: state_next = ST_RHO;
      ST_RHO:  state_next = (ap_c > 64'(term)) ? ST_DRWA : ST_QRY;
      ST_DRWA: state_next = ST_DRWB;
      ST_DRWB: state_next = ST_QRY;
      ST_QRY:  state_next = u_r ? ST_URD : ST_FIN;
      ST_URD:  state_next = ST_USQ;
      ST_USQ:  state_next = ST_UT;
      ST_UT:   state_next = ST_UPRD;
      ST_UPRD: state_next = ST_UDIV;
      ST_UDIV: state_next = div_done ? ST_USUB : ST_UDIV;
      ST_USUB: state_next = ST_UM;
      ST_UM:   state_next = ST_UST;
      ST_UST:  state_next = ST_UWR;
      ST_UWR:  state_next = (idx + PW'(1) == nfeat) ? ST_FIN : ST_URD;
      ST_FIN:  state_next = out_free ? ST_IDLE : ST_FIN;
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control outputs: handshake, memory ports and divider start.
  // ---------------------------------------------------------------------------
  always_comb begin
    in_ch.ready = (state == ST_IDLE);
    smp_we      = accept && has_room;
    smp_waddr   = pos[AW-1:0];
    upd_we      = (state == ST_UWR);
    w_raddr     = (state == ST_IDLE) ? pos[AW-1:0] : idx[AW-1:0];
    rd_addr     = (state == ST_ACC) ? pos[AW-1:0] : idx[AW-1:0];
    div_start   = 1'b0;
    div_dvd     = sq_prod;
    div_dvs     = 64'(den_reg);
    if (state == ST_DEC && mode == MODE_RHO && rrv != 49'd0) begin
      div_start = 1'b1;
      div_dvd   = {v, 16'd0};
      div_dvs   = 64'(rrv);
    end else if (state == ST_UPRD) begin
      div_start = 1'b1;
      div_dvd   = 64'(s_reg) * 64'(t_reg);
    end
  end

  // Saturated weight write-back.
  always_comb begin
    if (nw > 39'sd2147483647) begin
      w_wdata = 32'sh7FFF_FFFF;
    end else if (nw < -39'sd2147483648) begin
      w_wdata = 32'sh8000_0000;
    end else begin
      w_wdata = nw[31:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      score   <= '0;
      nonzero <= 1'b0;
      fill    <= '0;
      tp      <= '0;
      tn      <= '0;
      fp      <= '0;
      fn      <= '0;
      qc      <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            x_reg     <= in_ch.feature;
            last_reg  <= in_ch.last;
            label_reg <= in_ch.label;
            draw_reg  <= in_ch.random_draw;
            if (has_room && in_ch.feature != 16'sd0) begin
              nonzero <= 1'b1;
            end
          end
        end
        ST_ACC: begin
          score <= score + 64'(acc_prod);
          pos   <= pos + PW'(1);
        end
        ST_END: begin
          nfeat  <= pos;
          idx    <= '0;
          v      <= '0;
          skip_r <= !nonzero;
          pred   <= 1'b0;
          q_r    <= 1'b0;
          u_r    <= 1'b0;
        end
        ST_NSQ: begin
          xs    <= $signed(smp_rd);
          x2    <= smp_sq;
          s_reg <= c_eff;
        end
        ST_NACC: begin
          v   <= v + VW'(sq_prod[62:31]);
          idx <= idx + PW'(1);
        end
        ST_DEC: begin
          pred    <= !score[63];
          den_reg <= (rrv == 49'd0) ? 49'd1 : rrv;
          hq      <= '0;
          mag_sel <= ap_c;
          if (!score[63] == label_reg) begin
            if (label_reg) begin
              if (tp != '1) tp <= tp + 32'd1;
            end else begin
              if (tn != '1) tn <= tn + 32'd1;
            end
          end else if (!score[63]) begin
            if (fp != '1) fp <= fp + 32'd1;
          end else begin
            if (fn != '1) fn <= fn + 32'd1;
          end
          if (mode == MODE_ALWAYS) begin
            q_r <= 1'b1;
            u_r <= hinge_c;
          end else if (mode == MODE_FIXED) begin
            q_r <= 32'(draw_reg) <= sample_b;
            u_r <= (32'(draw_reg) <= sample_b) && hinge_c;
          end
        end
        ST_HDIV: begin
          if (div_done) begin
            hq <= div_q[16:0];
          end
        end
        ST_HMUL: h <= 40'((57'(rr) * 57'(hq)) >> 16);
        ST_TERM: term <= 59'((64'(h[39:8]) * 64'(step_eta)) >> 5);
        ST_RHO: begin
          if (ap_c > 64'(term)) begin
            mag_sel <= ap_c - 64'(term);
          end else begin
            q_r <= 1'b1;
            u_r <= hinge_c;
          end
        end
        ST_DRWA: s_draw <= 48'(sample_b) + 48'(p_cap);
        ST_DRWB: begin
          q_r <= draw_ok;
          u_r <= draw_ok && ((mode == MODE_RHO) ? (pred != label_reg) : hinge_c);
        end
        ST_QRY: begin
          idx <= '0;
          if (q_r && qc != '1) begin
            qc <= qc + 32'd1;
          end
        end
        ST_USQ: begin
          xs    <= $signed(smp_rd);
          x2    <= smp_sq;
          s_reg <= c_eff;
          w_reg <= w_eff;
        end
        ST_UT:   t_reg <= sq_prod[62:31];
        ST_UDIV: begin
          if (div_done) begin
            ds <= div_q;
          end
        end
        ST_USUB: snew <= (64'(s_reg) > ds) ? (s_reg - ds[31:0]) : 32'd0;
        ST_UM:   m <= 21'((48'(snew) * 48'(ax)) >> 27);
        ST_UST:  step <= 37'((53'(m) * 53'(step_eta)) >> 16);
        ST_UWR: begin
          // Entries are written in ascending order, so a mark of the highest
          // written index tells which entries hold real data.
          if (idx >= fill) fill <= idx + PW'(1);
          idx <= idx + PW'(1);
        end
        ST_FIN: begin
          if (out_free) begin
            pos     <= '0;
            score   <= '0;
            nonzero <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      out_ch.predicted_label <= pred;
      out_ch.queried         <= q_r;
      out_ch.updated         <= u_r;
      out_ch.skipped         <= skip_r;
      out_ch.true_pos_count  <= tp;
      out_ch.true_neg_count  <= tn;
      out_ch.false_pos_count <= fp;
      out_ch.false_neg_count <= fn;
      out_ch.query_count     <= qc;
    end
  end

  // ---------------------------------------------------------------------------
  // Memories and divider.
  // ---------------------------------------------------------------------------
  arow_ram #(.WIDTH(16), .DEPTH(FEATURES)) u_smp (
    .clk(clk), .we(smp_we), .waddr(smp_waddr), .wdata(in_ch.feature),
    .raddr(idx[AW-1:0]), .rdata(smp_rd)
  );

  arow_ram #(.WIDTH(32), .DEPTH(FEATURES)) u_wgt (
    .clk(clk), .we(upd_we), .waddr(idx[AW-1:0]), .wdata(w_wdata),
    .raddr(w_raddr), .rdata(w_rd)
  );

  arow_ram #(.WIDTH(32), .DEPTH(FEATURES)) u_cnf (
    .clk(clk), .we(upd_we), .waddr(idx[AW-1:0]), .wdata(snew),
    .raddr(idx[AW-1:0]), .rdata(c_rd)
  );

  arow_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dvd),
    .divisor(div_dvs), .done(div_done), .quotient(div_q)
  );

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_upd_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UWR) |-> (idx < nfeat))
    else $error("update write beyond the stored sample");

  a_result_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && out_free) |=> (out_ch.valid && state == ST_IDLE))
    else $error("result beat not presented after finish");

  a_skip_clean: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !(out_ch.skipped && (out_ch.queried || out_ch.updated)))
    else $error("skipped sample reports a query or update");

  a_div_waits: assert property (@(posedge clk) disable iff (rst)
    (div_done && state != ST_HDIV) |-> (state == ST_UDIV))
    else $error("divider finished outside a wait state");

endmodule

`default_nettype wire

### test/arow_learner_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arow_learner_checker
// Watches the feature and result channels and the register port of the
// diagonal AROW learner, keeps its own copy of weights, confidences and
// counts, and compares every result beat with the verdict of its own model.
// ----------------------------------------------------------------------------

module arow_learner_checker (
  input  logic  clk,
  input  logic  rst,
  arow_in_if    in_ch,
  arow_out_if   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int    fail_count,
  output int    pending,
  output int    results_seen,
  output int    updates_seen,
  output int    skips_seen
);

  import arow_pkg::*;

  localparam int NF = 256;

  typedef struct packed {
    logic        pred;
    logic        queried;
    logic        updated;
    logic        skipped;
    logic [31:0] tp;
    logic [31:0] tn;
    logic [31:0] fp;
    logic [31:0] fn;
    logic [31:0] qc;
  } verdict_t;

  // Model state of the learner.
  int                 wt [NF];
  bit [31:0]          sig [NF];
  logic signed [15:0] sample_x [NF];
  int                 pos;
  longint             score;
  bit                 any_nonzero;
  bit [31:0]          tally [5];
  bit [1:0]           mode_q;
  bit [31:0]          r_q, eta_q, b_q;

  verdict_t verdict_q[$];

  function automatic void bump(int k);
    if (tally[k] != 32'hFFFF_FFFF) tally[k]++;
  endfunction

  function automatic bit [63:0] conf_term(int i);
    longint    x;
    bit [63:0] x2;
    x = sample_x[i];
    x2 = x * x;
    return (x2 * {32'b0, sig[i]}) >> 31;
  endfunction

  // Margin draw test: d * (b + P) <= b in Q.16, P capped.
  function automatic bit margin_query(bit [63:0] d, bit [63:0] mag28);
    bit [63:0] p, s;
    p = mag28 >> 12;
    if (p > 64'(MAG_CAP)) p = 64'(MAG_CAP);
    s = {32'b0, b_q} + p;
    if (s == 0) return 1'b0;
    return d * s <= ({32'b0, b_q} << 16);
  endfunction

  // Shrink the confidences, then step the weights with the new ones.
  function automatic void arow_update(int n, bit [63:0] v, bit ypos);
    bit [63:0] denom, t, s, ds, ax, m;
    longint    x, step, nw;
    denom = v + ({32'b0, r_q} << 8);
    if (denom == 0) denom = 1;
    for (int i = 0; i < n; i++) begin
      x = sample_x[i];
      t = conf_term(i);
      s = {32'b0, sig[i]};
      ds = (s * t) / denom;
      s = (s > ds) ? s - ds : 64'd0;
      sig[i] = s[31:0];
      ax = (x < 0) ? -x : x;
      m = (s * ax) >> 27;
      step = longint'((m * {32'b0, eta_q}) >> 16);
      if ((x < 0) != !ypos) step = -step;
      nw = longint'(wt[i]) + step;
      if (nw > 64'sd2147483647) nw = 64'sd2147483647;
      if (nw < -64'sd2147483648) nw = -64'sd2147483648;
      wt[i] = int'(nw);
    end
  endfunction

  // One accepted feature beat; on the last beat a verdict is queued.
  function automatic void take_feature(logic signed [15:0] f, logic lab,
                                       logic [15:0] d, logic lst);
    longint    p;
    bit [63:0] ap, v, rr, h, term;
    bit        hinge, pred, q, u, sk;
    verdict_t  res;
    if (pos < NF) begin
      sample_x[pos] = f;
      score += longint'(f) * longint'(wt[pos]);
      if (f != 0) any_nonzero = 1'b1;
      pos++;
    end
    if (!lst) return;
    pred = 0; q = 0; u = 0; sk = 0;
    if (!any_nonzero) begin
      sk = 1;
    end else begin
      p = score;
      ap = (p < 0) ? 64'(-p) : 64'(p);
      hinge = lab ? (p < ONE_Q28) : (p > -ONE_Q28);
      v = 0;
      for (int i = 0; i < pos; i++) v += conf_term(i);
      pred = (p >= 0);
      if (pred == lab) bump(lab ? 0 : 1);
      else bump(pred ? 2 : 3);
      case (mode_q)
        MODE_ALWAYS: begin
          q = 1;
          u = hinge;
        end
        MODE_MARGIN: begin
          q = margin_query({48'b0, d}, ap);
          u = q && hinge;
        end
        MODE_RHO: begin
          rr = {32'b0, r_q} << 8;
          h = 0;
          if (rr + v != 0) h = (rr * ((v << 16) / (rr + v))) >> 16;
          term = ((h >> 8) * {32'b0, eta_q}) >> 5;
          if (ap > term) begin
            q = margin_query({48'b0, d}, ap - term);
            u = q && (pred != lab);
          end else begin
            q = 1;
            u = hinge;
          end
        end
        default: begin
          q = ({16'b0, d} <= b_q);
          u = q && hinge;
        end
      endcase
      if (q) bump(4);
      if (u) arow_update(pos, v, lab);
    end
    pos = 0;
    score = 0;
    any_nonzero = 0;
    res = '{pred, q, u, sk, tally[0], tally[1], tally[2], tally[3], tally[4]};
    verdict_q.push_back(res);
  endfunction

  function automatic void field_check(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
      fail_count++;
    end
  endfunction

  // Compare result beats first, then feed the model with feature beats.
  always @(posedge clk) begin
    verdict_t e;
    if (rst) begin
      for (int i = 0; i < NF; i++) begin
        wt[i] = 0;
        sig[i] = ONE_Q31;
      end
      pos = 0;
      score = 0;
      any_nonzero = 0;
      for (int k = 0; k < 5; k++) tally[k] = 0;
      mode_q = MODE_ALWAYS;
      r_q = REG_RESET;
      eta_q = REG_RESET;
      b_q = REG_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODE:     mode_q = cfg_data[1:0];
          CFG_REG_R:    r_q = cfg_data;
          CFG_STEP_ETA: eta_q = cfg_data;
          default:      b_q = cfg_data;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (verdict_q.size() == 0) begin
          $display("%0t: result beat with no sample pending", $time);
          fail_count++;
        end else begin
          e = verdict_q.pop_front();
          if (out_ch.updated) updates_seen++;
          if (out_ch.skipped) skips_seen++;
          field_check("predicted_label", 32'(e.pred), 32'(out_ch.predicted_label));
          field_check("queried", 32'(e.queried), 32'(out_ch.queried));
          field_check("updated", 32'(e.updated), 32'(out_ch.updated));
          field_check("skipped", 32'(e.skipped), 32'(out_ch.skipped));
          field_check("true_pos_count", e.tp, out_ch.true_pos_count);
          field_check("true_neg_count", e.tn, out_ch.true_neg_count);
          field_check("false_pos_count", e.fp, out_ch.false_pos_count);
          field_check("false_neg_count", e.fn, out_ch.false_neg_count);
          field_check("query_count", e.qc, out_ch.query_count);
        end
      end
      if (in_ch.valid && in_ch.ready)
        take_feature(in_ch.feature, in_ch.label, in_ch.random_draw, in_ch.last);
    end
    pending = verdict_q.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
    results_seen = 0;
    updates_seen = 0;
    skips_seen = 0;
  end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives samples of features into the AROW learner under several register
// settings and handshake pressures; the checker beside the block judges the
// result beats.
// ----------------------------------------------------------------------------

module testbench;
  import arow_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  int          fail_count, pending, results_seen, updates_seen, skips_seen;
  int          beats_sent;
  int          tx_idle_pct, rx_idle_pct;
  int          cycles;
  bit          hold_req;

  arow_in_if  in_ch ();
  arow_out_if out_ch ();

  arow_diagonal_active_learner_top dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  arow_learner_checker checker_i (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .results_seen(results_seen),
    .updates_seen(updates_seen), .skips_seen(skips_seen)
  );

  // Clock.
  initial clk = 0;
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Watchdog.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("arow_diagonal_active_learner_top regression: fail");
      $finish;
    end
  end

  // Result receiver: random stalls, or one long hold-off when asked for.
  initial begin
    out_ch.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 0;
        repeat (800) @(negedge clk);
        hold_req = 0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  function automatic logic signed [15:0] pick_feature();
    case ($urandom_range(0, 9))
      0: return 16'sd0;
      1: return 16'sd32767;
      2: return -16'sd32768;
      3: return 16'($signed($urandom_range(0, 128)) - 64);
      default: return 16'($urandom);
    endcase
  endfunction

  // One feature beat; the sender may idle first.
  task automatic send_beat(logic signed [15:0] f, logic lab, logic [15:0] d, logic lst);
    if (beats_sent < 283) begin
      tx_idle_pct = 10;
      rx_idle_pct = 88;
    end else if (beats_sent < 566) begin
      tx_idle_pct = 88;
      rx_idle_pct = 10;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.valid <= 1;
    in_ch.feature <= f;
    in_ch.label <= lab;
    in_ch.random_draw <= d;
    in_ch.last <= lst;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    beats_sent++;
  endtask

  // Whole sample; label and draw matter only on the last beat.
  task automatic send_sample(int n, bit zero, logic lab, logic [15:0] d);
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) send_beat(zero ? 16'sd0 : pick_feature(), lab, d, 1'b1);
      else send_beat(zero ? 16'sd0 : pick_feature(), 1'($urandom), 16'($urandom), 1'b0);
    end
  endtask

  task automatic send_fixed(logic signed [15:0] a, logic signed [15:0] b, logic lab,
                            logic [15:0] d);
    send_beat(a, 1'b0, 16'd0, 1'b0);
    send_beat(b, lab, d, 1'b1);
  endtask

  task automatic random_sample();
    int          n;
    logic [15:0] d;
    n = $urandom_range(1, 8);
    case ($urandom_range(0, 9))
      0: d = 16'd0;
      1: d = 16'hFFFF;
      default: d = 16'($urandom);
    endcase
    send_sample(n, $urandom_range(0, 99) < 6, 1'($urandom), d);
  endtask

  // Wait until every result is in and the block has settled.
  task automatic drain();
    in_ch.valid <= 0;
    wait (pending == 0);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
  endtask

  logic [1:0]  ph_mode [8] = '{MODE_MARGIN, MODE_RHO, MODE_FIXED, MODE_RHO,
                               MODE_MARGIN, MODE_ALWAYS, MODE_FIXED, MODE_RHO};
  logic [31:0] ph_r    [8] = '{32'h10000, 32'h10000, 32'd1, 32'hFFFFFFFF,
                               32'd1, 32'hFFFFFFFF, 32'd2048, 32'd1};
  logic [31:0] ph_eta  [8] = '{32'h10000, 32'h8000, 32'd0, 32'hFFFFFFFF,
                               32'd4096, 32'h100000, 32'h10000, 32'h10000};
  logic [31:0] ph_b    [8] = '{32'h10000, 32'h10000, 32'd0, 32'hFFFFFFFF,
                               32'd0, 32'h8000, 32'hFFFFFFFF, 32'd8192};

  initial begin
    int start;
    rst = 1;
    cfg_we = 0;
    cfg_index = CFG_MODE;
    cfg_data = 0;
    in_ch.valid = 0;
    in_ch.feature = 0;
    in_ch.label = 0;
    in_ch.random_draw = 0;
    in_ch.last = 0;
    hold_req = 0;
    beats_sent = 0;
    tx_idle_pct = 10;
    rx_idle_pct = 88;
    repeat (4) @(negedge clk);
    rst = 0;

    // Directed samples under the reset settings: all-zero samples, extreme
    // features of both signs, and repeats that build up the weights.
    send_beat(16'sd0, 1'b1, 16'd0, 1'b1);
    send_beat(16'sd32767, 1'b1, 16'hFFFF, 1'b1);
    send_beat(-16'sd32768, 1'b0, 16'd0, 1'b1);
    send_beat(-16'sd32768, 1'b1, 16'h8000, 1'b1);
    send_sample(3, 1'b1, 1'b0, 16'd5);
    send_fixed(16'sd1, -16'sd1, 1'b0, 16'd0);
    send_fixed(16'sd32767, 16'sd32767, 1'b1, 16'hFFFF);
    send_fixed(16'sd0, 16'sd4096, 1'b0, 16'd1);
    repeat (3) send_fixed(16'sd4096, -16'sd4096, 1'b1, 16'd100);
    send_fixed(-16'sd32768, 16'sd32767, 1'b0, 16'hFFFF);
    send_beat(16'sd100, 1'b0, 16'd0, 1'b1);

    // One sample longer than the block holds: the extra features are dropped.
    send_sample(260, 1'b0, 1'b1, 16'd0);

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      write_reg(CFG_MODE, {30'b0, ph_mode[ph]});
      write_reg(CFG_REG_R, ph_r[ph]);
      write_reg(CFG_STEP_ETA, ph_eta[ph]);
      write_reg(CFG_SAMPLE_B, ph_b[ph]);
      cfg_we <= 0;
      @(negedge clk);
      start = beats_sent;
      while (beats_sent - start < 70) begin
        if (ph == 3 && beats_sent - start < 8 && !hold_req) hold_req = 1;
        if (ph == 5 && beats_sent - start > 50 && beats_sent - start < 60) begin
          in_ch.valid <= 0;
          wait (pending == 0);
          @(negedge clk);
        end
        random_sample();
      end
    end

    drain();
    repeat (200) @(negedge clk);
    $display("Sent %0d feature beats under 9 register settings; %0d results checked,",
             beats_sent, results_seen);
    $display("of which %0d updated the model and %0d were all-zero skips.",
             updates_seen, skips_seen);
    if (fail_count == 0) begin
      $display("arow_diagonal_active_learner_top regression: pass");
    end else begin
      $display("arow_diagonal_active_learner_top regression: fail");
    end
    $finish;
  end

endmodule
